FILE: hdl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg
// shared widths, constants, the arctangent step table and the command bundle
// ----------------------------------------------------------------------------
package ata_pkg;

    localparam int ACC_W         = 16;   // raw accelerometer sample
    localparam int TILT_W        = 15;   // tilt in hundredths of a degree
    localparam int SUMSQ_W       = 32;   // b*b + c*c
    localparam int RAD_W         = 48;   // radicand, sum of squares << 16
    localparam int ROOT_W        = 24;   // integer square root of radicand
    localparam int REM_W         = 27;   // partial remainder of the root
    localparam int ROT_W         = 27;   // cordic x and y
    localparam int ANG_W         = 32;   // cordic angle, 2^-30 rad units
    localparam int PROD_W        = 44;   // |angle| * 5730
    localparam int STEP_W        = 5;    // iteration index
    localparam int TABLE_LEN     = 24;
    localparam int DEFAULT_STEPS = 16;

    localparam logic [12:0]       SCALE_CDEG   = 13'd5730;
    localparam logic [TILT_W-2:0] QUARTER_TURN = 14'd9001;
    localparam logic [7:0]        STATUS_MASK  = 8'h03;

    typedef struct packed {
        logic              accept;     // request taken, latch sample
        logic              square;     // form the two squares
        logic              load_root;  // start the square root
        logic              root_step;  // one root digit
        logic              load_rot;   // start the rotation
        logic              rot_step;   // one cordic iteration
        logic              scale;      // scale angle to hundredths
        logic              finish;     // round, saturate, load result
        logic [STEP_W-1:0] step;       // iteration index
    } cmd_t;

    // atan(2^-i) * 2^30, truncated
    function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles
// tilt of each accelerometer axis against the other two, in centidegrees
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries a status byte and a raw x/y/z
//   triple; bit 0 or bit 1 of the status byte marks a new sample, which is
//   latched, otherwise the last latched triple is used again
//   output channel (out_valid/out_ready) gives tilt_x/y/z in hundredths of
//   a degree (-9001..9001), sample_fresh and the degenerate flag
//   one request is processed at a time and the next is taken the cycle after
//   the result is loaded; most of the work falls to the root unit of each
//   lane (one digit a cycle, 24 digits) followed by the cordic unit (one
//   iteration a cycle); the three axes run side by side in their own lanes
//   a result waits in the output register while the receiver stalls; the
//   next request is still accepted and worked on, and holds in its last
//   stage until the waiting result is taken
//   reset clears the held triple to zero and empties the output register
// ----------------------------------------------------------------------------
module accel_tilt_angles
#(
    parameter int CORDIC_STEPS = ata_pkg::DEFAULT_STEPS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         status_byte,
    input  logic signed [ata_pkg::ACC_W-1:0]   accel_x,
    input  logic signed [ata_pkg::ACC_W-1:0]   accel_y,
    input  logic signed [ata_pkg::ACC_W-1:0]   accel_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ata_pkg::TILT_W-1:0]  tilt_x,
    output logic signed [ata_pkg::TILT_W-1:0]  tilt_y,
    output logic signed [ata_pkg::TILT_W-1:0]  tilt_z,
    output logic                               sample_fresh,
    output logic                               degenerate
);

    // command bundle from sequencer to datapath
    ata_pkg::cmd_t cmd;

    ata_ctrl
    #(
        .CORDIC_STEPS (CORDIC_STEPS)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ata_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status_byte  (status_byte),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .tilt_x       (tilt_x),
        .tilt_y       (tilt_y),
        .tilt_z       (tilt_z),
        .sample_fresh (sample_fresh),
        .degenerate   (degenerate)
    );

`ifndef SYNTHESIS
    // one request in flight: after acceptance the input side closes
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // a degenerate axis always reports zero tilt
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (tilt_x == 0 || tilt_y == 0 || tilt_z == 0))
        else $error("degenerate flag without a zero tilt");

    // saturation keeps every tilt within a quarter turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tilt_x >= -9001 && tilt_x <= 9001 && tilt_y >= -9001
                       && tilt_y <= 9001 && tilt_z >= -9001 && tilt_z <= 9001))
        else $error("tilt beyond a quarter turn");
`endif

endmodule

FILE: hdl/ata_lane.sv
// ----------------------------------------------------------------------------
// ata_lane
// one axis: sum of squares, digit-serial root, cordic vectoring, scaling
// ----------------------------------------------------------------------------
module ata_lane
(
    input  logic                               clk,
    input  ata_pkg::cmd_t                      cmd,
    input  logic signed [ata_pkg::ACC_W-1:0]   num,
    input  logic signed [ata_pkg::ACC_W-1:0]   oth_b,
    input  logic signed [ata_pkg::ACC_W-1:0]   oth_c,
    output logic signed [ata_pkg::TILT_W-1:0]  tilt,
    output logic                               degen
);

    logic [ata_pkg::SUMSQ_W-1:0]        sq_b_reg, sq_c_reg;
    logic [ata_pkg::RAD_W-1:0]          rad_reg;
    logic [ata_pkg::REM_W-1:0]          rem_reg;
    logic [ata_pkg::ROOT_W-1:0]         root_reg;
    logic signed [ata_pkg::ROT_W-1:0]   x_reg, y_reg;
    logic signed [ata_pkg::ANG_W-1:0]   z_reg;
    logic [ata_pkg::PROD_W-1:0]         prod_reg;
    logic signed [ata_pkg::TILT_W-1:0]  tilt_reg;
    logic                               degen_reg;

    logic signed [ata_pkg::SUMSQ_W-1:0] prod_b, prod_c;
    logic [ata_pkg::SUMSQ_W-1:0]        sum_sq;
    logic [ata_pkg::REM_W-1:0]          rem_sh, trial;
    logic signed [ata_pkg::ROT_W-1:0]   xs, ys;
    logic signed [ata_pkg::ANG_W-1:0]   t_step;
    logic [ata_pkg::ANG_W-1:0]          mag;
    logic [ata_pkg::PROD_W:0]           rnd;
    logic [ata_pkg::TILT_W-1:0]         rmag;
    logic [ata_pkg::TILT_W-2:0]         smag;
    logic signed [ata_pkg::TILT_W-1:0]  tilt_next;
    logic                               degen_next;

    assign prod_b = oth_b * oth_b;
    assign prod_c = oth_c * oth_c;
    assign sum_sq = sq_b_reg + sq_c_reg;

    // restoring root, two radicand bits per step
    assign rem_sh = {rem_reg[ata_pkg::REM_W-3:0], rad_reg[ata_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    assign xs     = x_reg >>> cmd.step;
    assign ys     = y_reg >>> cmd.step;
    assign t_step = signed'(ata_pkg::atan_entry(cmd.step));

    assign mag  = z_reg[ata_pkg::ANG_W-1] ? ata_pkg::ANG_W'(-z_reg) : ata_pkg::ANG_W'(z_reg);
    assign rnd  = {1'b0, prod_reg} + (ata_pkg::PROD_W+1)'(64'd1 << 29);
    assign rmag = rnd[30 +: ata_pkg::TILT_W];
    assign smag = (rmag > {1'b0, ata_pkg::QUARTER_TURN}) ? ata_pkg::QUARTER_TURN
                                                         : rmag[ata_pkg::TILT_W-2:0];

    always_comb
    begin
        degen_next = 1'b0;
        if (root_reg == '0)
        begin
            if (num == '0)
            begin
                tilt_next  = '0;
                degen_next = 1'b1;
            end
            else if (num[ata_pkg::ACC_W-1])
            begin
                tilt_next = -signed'({1'b0, ata_pkg::QUARTER_TURN});
            end
            else
            begin
                tilt_next = signed'({1'b0, ata_pkg::QUARTER_TURN});
            end
        end
        else if (num == '0)
        begin
            tilt_next = '0;
        end
        else if (z_reg[ata_pkg::ANG_W-1])
        begin
            tilt_next = -signed'({1'b0, smag});
        end
        else
        begin
            tilt_next = signed'({1'b0, smag});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            sq_b_reg <= unsigned'(prod_b);
            sq_c_reg <= unsigned'(prod_c);
        end
        if (cmd.load_root)
        begin
            rad_reg  <= {sum_sq, 16'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg <= {rad_reg[ata_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ata_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ata_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.load_rot)
        begin
            x_reg <= signed'({3'b000, root_reg});
            y_reg <= signed'({{3{num[ata_pkg::ACC_W-1]}}, num, 8'd0});
            z_reg <= '0;
        end
        else if (cmd.rot_step)
        begin
            if (!y_reg[ata_pkg::ROT_W-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t_step;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t_step;
            end
        end
        if (cmd.scale)
        begin
            prod_reg <= mag[ata_pkg::ANG_W-2:0] * ata_pkg::SCALE_CDEG;
        end
        if (cmd.finish)
        begin
            tilt_reg  <= tilt_next;
            degen_reg <= degen_next;
        end
    end

    assign tilt  = tilt_reg;
    assign degen = degen_reg;

endmodule

FILE: hdl/ata_dp.sv
// ----------------------------------------------------------------------------
// ata_dp
// held sample triple and the three axis lanes
// ----------------------------------------------------------------------------
module ata_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  ata_pkg::cmd_t                      cmd,
    input  logic [7:0]                         status_byte,
    input  logic signed [ata_pkg::ACC_W-1:0]   accel_x,
    input  logic signed [ata_pkg::ACC_W-1:0]   accel_y,
    input  logic signed [ata_pkg::ACC_W-1:0]   accel_z,
    output logic signed [ata_pkg::TILT_W-1:0]  tilt_x,
    output logic signed [ata_pkg::TILT_W-1:0]  tilt_y,
    output logic signed [ata_pkg::TILT_W-1:0]  tilt_z,
    output logic                               sample_fresh,
    output logic                               degenerate
);

    logic signed [ata_pkg::ACC_W-1:0] held_x_reg, held_y_reg, held_z_reg;
    logic                             fresh_reg, fresh_out_reg;
    logic                             fresh;
    logic                             dg_x, dg_y, dg_z;

    assign fresh = |(status_byte & ata_pkg::STATUS_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg <= '0;
            held_y_reg <= '0;
            held_z_reg <= '0;
        end
        else if (cmd.accept && fresh)
        begin
            held_x_reg <= accel_x;
            held_y_reg <= accel_y;
            held_z_reg <= accel_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            fresh_reg <= fresh;
        end
        if (cmd.finish)
        begin
            fresh_out_reg <= fresh_reg;
        end
    end

    ata_lane u_lane_x
    (
        .clk   (clk),
        .cmd   (cmd),
        .num   (held_x_reg),
        .oth_b (held_y_reg),
        .oth_c (held_z_reg),
        .tilt  (tilt_x),
        .degen (dg_x)
    );

    ata_lane u_lane_y
    (
        .clk   (clk),
        .cmd   (cmd),
        .num   (held_y_reg),
        .oth_b (held_x_reg),
        .oth_c (held_z_reg),
        .tilt  (tilt_y),
        .degen (dg_y)
    );

    ata_lane u_lane_z
    (
        .clk   (clk),
        .cmd   (cmd),
        .num   (held_z_reg),
        .oth_b (held_x_reg),
        .oth_c (held_y_reg),
        .tilt  (tilt_z),
        .degen (dg_z)
    );

    assign sample_fresh = fresh_out_reg;
    assign degenerate   = dg_x | dg_y | dg_z;

endmodule

FILE: hdl/ata_ctrl.sv
// ----------------------------------------------------------------------------
// ata_ctrl
// sequencer for squares, root digits, cordic iterations and result hand-off
// ----------------------------------------------------------------------------
module ata_ctrl
#(
    parameter int CORDIC_STEPS = ata_pkg::DEFAULT_STEPS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output ata_pkg::cmd_t cmd
);

    localparam int ROT_N = (CORDIC_STEPS < ata_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                               : ata_pkg::TABLE_LEN;
    localparam logic [ata_pkg::STEP_W-1:0] LAST_ROT  = ata_pkg::STEP_W'(ROT_N - 1);
    localparam logic [ata_pkg::STEP_W-1:0] LAST_ROOT = ata_pkg::STEP_W'(ata_pkg::ROOT_W - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SQUARE  = 3'd1;
    localparam logic [2:0] S_LOAD    = 3'd2;
    localparam logic [2:0] S_ROOT    = 3'd3;
    localparam logic [2:0] S_ROTLOAD = 3'd4;
    localparam logic [2:0] S_ROT     = 3'd5;
    localparam logic [2:0] S_SCALE   = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [ata_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_root = 1'b1;
                cnt_next      = '0;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == LAST_ROOT)
                begin
                    cnt_next   = '0;
                    state_next = S_ROTLOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ROTLOAD:
            begin
                cmd.load_rot = 1'b1;
                state_next   = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (cnt_reg == LAST_ROT)
                begin
                    cnt_next   = '0;
                    state_next = S_SCALE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // result register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
